[design/rtc_pkg.sv]
// ----------------------------------------------------------------------------
// rtc_pkg: shared types, constants and helpers of the radix text converter
// Holds the word formats of both channels, status codes, register indexes,
// ASCII constants and the digit classification functions.
// ----------------------------------------------------------------------------
`default_nettype none

package rtc_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int RADIX_W       = 6;
    localparam int DIV_BITS      = 4;   // quotient bits resolved per divider step
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] DIGIT_BAD   = 6'd36;
    localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SRC  = 3'd1;
    localparam logic [2:0] ST_BAD_CHAR = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_BAD_DST  = 3'd4;

    // configuration register indexes
    localparam int             CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_RADIX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_RADIX = 1'b1;

    // ASCII
    localparam logic [7:0] ASC_MINUS = 8'h2D;
    localparam logic [7:0] ASC_0     = 8'h30;
    localparam logic [7:0] ASC_9     = 8'h39;
    localparam logic [7:0] ASC_UA    = 8'h41;
    localparam logic [7:0] ASC_UZ    = 8'h5A;
    localparam logic [7:0] ASC_LA    = 8'h61;
    localparam logic [7:0] ASC_LZ    = 8'h7A;
    localparam logic [7:0] ASC_NUL   = 8'h00;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_in;
    } t_in_word;

    typedef struct packed {
        logic [7:0] char_out;
        logic [2:0] status;
        logic       last_out;
    } t_out_word;

    // control part of one finished number, handed from front to back
    typedef struct packed {
        logic [2:0]         err;
        logic               neg;
        logic [RADIX_W-1:0] radix;
    } t_job_ctl;

    function automatic logic radix_ok(input logic [RADIX_W-1:0] r);
        return (r >= RADIX_MIN) && (r <= RADIX_MAX);
    endfunction

    // digit value 0..35, DIGIT_BAD for anything else
    function automatic logic [RADIX_W-1:0] char_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= ASC_0 && c <= ASC_9) begin
            v = c - ASC_0;
        end else if (c >= ASC_UA && c <= ASC_UZ) begin
            v = c - ASC_UA + {2'b00, DIGIT_TEN};
        end else if (c >= ASC_LA && c <= ASC_LZ) begin
            v = c - ASC_LA + {2'b00, DIGIT_TEN};
        end else begin
            v = {2'b00, DIGIT_BAD};
        end
        return v[RADIX_W-1:0];
    endfunction

    function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [7:0] r;
        if (d < DIGIT_TEN) begin
            r = ASC_0 + {2'b00, d};
        end else begin
            r = ASC_UA + {2'b00, d - DIGIT_TEN};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/rtc_front.sv]
// ----------------------------------------------------------------------------
// rtc_front: character intake and accumulation
// Classifies each character, accumulates the magnitude with an overflow
// check and pushes one job per number into the queue on the final character.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_front #(
    parameter int WORD_BITS = rtc_pkg::WORD_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_accept,
    input  rtc_pkg::t_in_word            i_in,
    input  wire [rtc_pkg::RADIX_W-1:0]   i_src_radix,
    input  wire [rtc_pkg::RADIX_W-1:0]   i_dst_radix,
    output logic                         o_push,
    output rtc_pkg::t_job_ctl            o_ctl,
    output logic [WORD_BITS-2:0]         o_mag
);

    localparam int MAG_W = WORD_BITS - 1;
    localparam int SUM_W = MAG_W + rtc_pkg::RADIX_W + 1;

    logic [MAG_W-1:0]            r_mag, n_mag;
    logic                        r_neg, n_neg;
    logic                        r_first;
    logic [2:0]                  r_err, n_err;
    logic [rtc_pkg::RADIX_W-1:0] digit;
    logic [SUM_W-1:0]            sum;
    logic [2:0]                  fin_err;

    assign digit = rtc_pkg::char_value(i_in.char_in);
    assign sum   = SUM_W'(r_mag) * SUM_W'(i_src_radix) + SUM_W'(digit);

    always_comb begin
        n_mag = r_mag;
        n_neg = r_neg;
        n_err = r_err;
        if (r_err == rtc_pkg::ST_OK) begin
            if (!rtc_pkg::radix_ok(i_src_radix)) begin
                n_err = rtc_pkg::ST_BAD_SRC;
            end else if (r_first && i_in.char_in == rtc_pkg::ASC_MINUS) begin
                n_neg = 1'b1;
            end else if (digit >= i_src_radix) begin
                n_err = rtc_pkg::ST_BAD_CHAR;
            end else if (sum[SUM_W-1:MAG_W] != '0) begin
                n_err = rtc_pkg::ST_OVERFLOW;
            end else begin
                n_mag = sum[MAG_W-1:0];
            end
        end
        fin_err = n_err;
        if (n_err == rtc_pkg::ST_OK && !rtc_pkg::radix_ok(i_dst_radix)) begin
            fin_err = rtc_pkg::ST_BAD_DST;
        end
    end

    assign o_push      = i_accept && i_in.last_in;
    assign o_ctl.err   = fin_err;
    assign o_ctl.neg   = n_neg;
    assign o_ctl.radix = i_dst_radix;
    assign o_mag       = n_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag   <= '0;
            r_neg   <= 1'b0;
            r_first <= 1'b1;
            r_err   <= rtc_pkg::ST_OK;
        end else if (i_accept) begin
            if (i_in.last_in) begin
                // drop the number, start fresh
                r_mag   <= '0;
                r_neg   <= 1'b0;
                r_first <= 1'b1;
                r_err   <= rtc_pkg::ST_OK;
            end else begin
                r_mag   <= n_mag;
                r_neg   <= n_neg;
                r_first <= 1'b0;
                r_err   <= n_err;
            end
        end
    end

endmodule

`default_nettype wire

[design/rtc_queue.sv]
// ----------------------------------------------------------------------------
// rtc_queue: short job queue between front and back
// A small register FIFO; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = rtc_pkg::QUEUE_DEPTH
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire [DATA_W-1:0]  i_data,
    input  wire               i_pop,
    output logic              o_full,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full job queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty job queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("job queue count out of range");

endmodule

`default_nettype wire

[design/rtc_back.sv]
// ----------------------------------------------------------------------------
// rtc_back: digit generation and output sequencer
// Divides the magnitude repeatedly by the destination radix, a few quotient
// bits per cycle, stores the digits and emits them most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_back #(
    parameter int WORD_BITS = rtc_pkg::WORD_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  rtc_pkg::t_job_ctl     i_ctl,
    input  wire [WORD_BITS-2:0]   i_mag,
    output logic                  o_pop,
    output logic                  o_strobe,
    output rtc_pkg::t_out_word    o_out
);

    localparam int MAG_W  = WORD_BITS - 1;
    localparam int DB     = rtc_pkg::DIV_BITS;
    localparam int RW     = rtc_pkg::RADIX_W;
    localparam int PAD_W  = ((MAG_W + DB - 1) / DB) * DB;
    localparam int STEPS  = PAD_W / DB;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int CNT_W  = $clog2(WORD_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_READ,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [PAD_W-1:0]   r_quo;
    logic [RW-1:0]      r_rem;
    logic [RW-1:0]      r_radix;
    logic               r_neg;
    logic [STEP_W-1:0]  r_step;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_idx;
    logic [RW-1:0]      r_rd;
    logic               r_strobe;
    rtc_pkg::t_out_word r_out;

    logic [RW-1:0]      r_digits [WORD_BITS];

    logic [PAD_W-1:0]   div_quo;
    logic [RW-1:0]      div_rem;
    logic               step_last;
    logic               wr_en;

    // restoring division, DB quotient bits per cycle
    always_comb begin
        logic [RW:0] t;
        div_rem = r_rem;
        div_quo = r_quo;
        for (int k = 0; k < DB; k++) begin
            t       = {div_rem, div_quo[PAD_W-1]};
            div_quo = {div_quo[PAD_W-2:0], 1'b0};
            if (t >= {1'b0, r_radix}) begin
                t          = t - {1'b0, r_radix};
                div_quo[0] = 1'b1;
            end
            div_rem = t[RW-1:0];
        end
    end

    assign step_last = (r_step == STEP_W'(STEPS - 1));
    assign wr_en     = (r_state == S_DIV) && step_last;
    assign o_pop     = (r_state == S_IDLE) && i_valid;
    assign o_strobe  = r_strobe;
    assign o_out     = r_out;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_digits[r_cnt] <= div_rem;
        end
        r_rd <= r_digits[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_neg   <= i_ctl.neg;
                        r_radix <= i_ctl.radix;
                        if (i_ctl.err != rtc_pkg::ST_OK) begin
                            r_out    <= '{rtc_pkg::ASC_NUL, i_ctl.err, 1'b1};
                            r_strobe <= 1'b1;
                        end else if (i_mag == '0) begin
                            r_out    <= '{rtc_pkg::ASC_0, rtc_pkg::ST_OK, 1'b1};
                            r_strobe <= 1'b1;
                        end else begin
                            r_quo   <= PAD_W'(i_mag);
                            r_rem   <= '0;
                            r_step  <= '0;
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_quo <= div_quo;
                    if (step_last) begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_rem  <= '0;
                        r_step <= '0;
                        if (div_quo == '0) begin
                            r_idx   <= r_cnt;
                            r_state <= r_neg ? S_SIGN : S_READ;
                        end
                    end else begin
                        r_rem  <= div_rem;
                        r_step <= r_step + 1'b1;
                    end
                end
                S_SIGN: begin
                    r_out    <= '{rtc_pkg::ASC_MINUS, rtc_pkg::ST_OK, 1'b0};
                    r_strobe <= 1'b1;
                    r_state  <= S_READ;
                end
                S_READ: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_out    <= '{rtc_pkg::digit_char(r_rd), rtc_pkg::ST_OK,
                                  (r_idx == '0)};
                    r_strobe <= 1'b1;
                    if (r_idx == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx - 1'b1;
                        r_state <= S_READ;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.status != rtc_pkg::ST_OK)
            |-> (o_out.last_out && o_out.char_out == rtc_pkg::ASC_NUL))
        else $error("error word must be a single final word with zero char");

    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_strobe || r_state == S_DIV))
        else $error("popped job neither emitted nor started dividing");

    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= CNT_W'(WORD_BITS - 1)))
        else $error("digit count beyond buffer depth");

endmodule

`default_nettype wire

[design/radix_text_converter.sv]
// ----------------------------------------------------------------------------
// radix_text_converter: signed number text conversion between radixes
// Reads a number as ASCII text one character per word and writes it back
// as ASCII text in another radix, or one status word on error.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_in with start high; the word is taken at the edge
//   where start is high and busy is low. Mark the final character with
//   last_in. An optional leading '-' makes the number negative.
//   Config channel: i_cfg_valid with i_cfg_index / i_cfg_data; o_cfg_ready is
//   always high. Write only while no number is in flight.
//   Output: each word appears on o_out for one cycle with o_strobe high. The
//   receiver cannot stall; it must take every strobed word.
// Operation:
//   A character that is not final only updates the partial number. The final
//   character pushes the number into a two-entry job queue; busy is high
//   while it is full. The back end picks up a job when idle; an error or
//   zero result is written out directly as a single word. Otherwise the
//   magnitude is divided by the destination radix, four quotient bits per
//   cycle and one full division per digit, then the sign is emitted if
//   negative and each digit is read from the buffer, then registered out.
// Reset: synchronous, active low; both radixes return to 10, the partial
//   number and the queue are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_text_converter #(
    parameter int WORD_BITS = rtc_pkg::WORD_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // input words
    input  wire                            start,
    output logic                           busy,
    input  rtc_pkg::t_in_word              i_in,
    // configuration writes
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [rtc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [rtc_pkg::RADIX_W-1:0]     i_cfg_data,
    // result words
    output logic                           o_strobe,
    output rtc_pkg::t_out_word             o_out
);

    localparam int MAG_W = WORD_BITS - 1;
    localparam int JOB_W = $bits(rtc_pkg::t_job_ctl) + MAG_W;

    logic [rtc_pkg::RADIX_W-1:0] r_src_radix;
    logic [rtc_pkg::RADIX_W-1:0] r_dst_radix;

    logic               accept;
    logic               push;
    rtc_pkg::t_job_ctl  front_ctl;
    logic [MAG_W-1:0]   front_mag;
    logic               q_full;
    logic               q_empty;
    logic               pop;
    logic [JOB_W-1:0]   q_head;
    rtc_pkg::t_job_ctl  back_ctl;
    logic [MAG_W-1:0]   back_mag;

    // hold off new characters while the job queue is full
    assign busy        = q_full;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_radix <= rtc_pkg::RADIX_RESET;
            r_dst_radix <= rtc_pkg::RADIX_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rtc_pkg::CFG_SRC_RADIX: r_src_radix <= i_cfg_data;
                rtc_pkg::CFG_DST_RADIX: r_dst_radix <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rtc_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in        (i_in),
        .i_src_radix (r_src_radix),
        .i_dst_radix (r_dst_radix),
        .o_push      (push),
        .o_ctl       (front_ctl),
        .o_mag       (front_mag)
    );

    rtc_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (rtc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_ctl, front_mag}),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_head)
    );

    // split the queue head back into control and magnitude
    assign back_ctl = rtc_pkg::t_job_ctl'(q_head[JOB_W-1:MAG_W]);
    assign back_mag = q_head[MAG_W-1:0];

    rtc_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!q_empty),
        .i_ctl    (back_ctl),
        .i_mag    (back_mag),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire
